// File: sv/assert_macros.svh
// Assertion macros used by the watchdog top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/lhw_pkg.sv
// Types and constants of the link heartbeat watchdog.
package lhw_pkg;

  typedef enum logic [1:0] {
    ST_INIT = 2'd0,
    ST_WAIT = 2'd1,
    ST_LOST = 2'd2,
    ST_OK   = 2'd3
  } status_t;

  localparam int RUN_WIDTH = 8;
  typedef logic [RUN_WIDTH-1:0] run_t;
  localparam run_t RUN_MAX = '1;

  localparam int TIMEOUT_RESET   = 500;
  localparam int PERIOD_RESET    = 200;
  localparam int LOST_THR_RESET  = 2;
  localparam int OK_THR_RESET    = 2;

  localparam logic [7:0] CFG_TIMEOUT  = 8'd0;
  localparam logic [7:0] CFG_PERIOD   = 8'd1;
  localparam logic [7:0] CFG_LOST_THR = 8'd2;
  localparam logic [7:0] CFG_OK_THR   = 8'd3;

  typedef struct packed {
    logic    fire;
    status_t status;
  } check_result_t;

endpackage

// File: sv/lhw_monitor.sv
// Heartbeat age, check timing, hysteresis runs and link status for one tick.
module lhw_monitor #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        heartbeat_arrived,
  input  logic [TICK_COUNT_WIDTH-1:0] timeout_ticks,
  input  logic [TICK_COUNT_WIDTH-1:0] check_period_ticks,
  input  lhw_pkg::run_t               lost_limit,
  input  lhw_pkg::run_t               ok_limit,
  output lhw_pkg::check_result_t      result
);
  import lhw_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;

  logic          heartbeat_seen;
  logic [TW:0]   heartbeat_age;
  logic [TW-1:0] check_phase;
  run_t          lost_run;
  run_t          ok_run;
  status_t       link_status;

  logic          heartbeat_seen_next;
  logic [TW:0]   heartbeat_age_next;
  logic [TW-1:0] check_phase_next;
  run_t          lost_run_next;
  run_t          ok_run_next;
  status_t       link_status_next;

  logic [TW:0]   phase_inc;
  logic          check;
  logic          want_valid;
  status_t       want;

  always_comb begin
    heartbeat_seen_next = heartbeat_seen | heartbeat_arrived;
    if (heartbeat_arrived) begin
      heartbeat_age_next = '0;
    end else if (heartbeat_age == '1) begin
      heartbeat_age_next = heartbeat_age;
    end else begin
      heartbeat_age_next = heartbeat_age + 1'b1;
    end

    phase_inc = {1'b0, check_phase} + 1'b1;
    check = !(phase_inc < {1'b0, check_period_ticks});
    check_phase_next = check ? '0 : phase_inc[TW-1:0];

    lost_run_next = lost_run;
    ok_run_next = ok_run;
    want_valid = 1'b0;
    want = ST_WAIT;
    if (check) begin
      if (!heartbeat_seen_next) begin
        lost_run_next = '0;
        ok_run_next = '0;
        want_valid = 1'b1;
        want = ST_WAIT;
      end else if (heartbeat_age_next > {1'b0, timeout_ticks}) begin
        lost_run_next = (lost_run == RUN_MAX) ? lost_run : lost_run + 1'b1;
        ok_run_next = '0;
        want_valid = (lost_run_next >= lost_limit);
        want = ST_LOST;
      end else begin
        ok_run_next = (ok_run == RUN_MAX) ? ok_run : ok_run + 1'b1;
        lost_run_next = '0;
        if (ok_run_next >= ok_limit) begin
          want_valid = 1'b1;
          want = ST_OK;
        end else if (link_status == ST_INIT) begin
          want_valid = 1'b1;
          want = ST_WAIT;
        end
      end
    end

    result.fire = want_valid && (want != link_status);
    result.status = want;
    link_status_next = result.fire ? want : link_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_seen <= 1'b0;
      heartbeat_age <= '0;
      check_phase <= '0;
      lost_run <= '0;
      ok_run <= '0;
      link_status <= ST_INIT;
    end else if (step) begin
      heartbeat_seen <= heartbeat_seen_next;
      heartbeat_age <= heartbeat_age_next;
      check_phase <= check_phase_next;
      lost_run <= lost_run_next;
      ok_run <= ok_run_next;
      link_status <= link_status_next;
    end
  end

endmodule

// File: sv/link_heartbeat_watchdog_unit.sv
// Top level of the link heartbeat watchdog: request registers, settings and result register.
// Each accepted request is one tick of elapsed time; one request is taken in every
// cycle while results are taken, and a status change is checked from the request register
// and then loaded into the result register. The rate is set by the single pass
// of the check logic between the request register and the result register; the request
// channel stalls only while a result waits in the result register and a request sits in
// the request register. Settings are written through the configuration channel, which
// is always ready, and should be written only while no request is in flight.
`include "assert_macros.svh"

module link_heartbeat_watchdog_unit #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        heartbeat_arrived,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lhw_pkg::status_t            new_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [TICK_COUNT_WIDTH-1:0] cfg_data
);
  import lhw_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;

  logic [TW-1:0] timeout_ticks;
  logic [TW-1:0] check_period_ticks;
  run_t          lost_limit;
  run_t          ok_limit;

  logic          s1_valid;
  logic          s1_heartbeat;
  logic          s1_advance;
  logic          load_result;
  check_result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TW'(TIMEOUT_RESET);
      check_period_ticks <= TW'(PERIOD_RESET);
      lost_limit <= RUN_WIDTH'(LOST_THR_RESET);
      ok_limit <= RUN_WIDTH'(OK_THR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_ticks <= cfg_data;
        CFG_PERIOD:   check_period_ticks <= cfg_data;
        CFG_LOST_THR: lost_limit <= cfg_data[RUN_WIDTH-1:0];
        CFG_OK_THR:   ok_limit <= cfg_data[RUN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_advance;
  assign load_result = s1_advance && result.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_heartbeat <= heartbeat_arrived;
    end
  end

  lhw_monitor #(
    .TICK_COUNT_WIDTH(TW)
  ) u_monitor (
    .clk               (clk),
    .rst               (rst),
    .step              (s1_advance),
    .heartbeat_arrived (s1_heartbeat),
    .timeout_ticks     (timeout_ticks),
    .check_period_ticks(check_period_ticks),
    .lost_limit        (lost_limit),
    .ok_limit          (ok_limit),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= result.fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      new_status <= result.status;
    end
  end

  // The status never returns to INIT once it has left it.
  `ASSERT_HOLDS(a_no_init_result, clk, rst, !out_valid || (new_status != ST_INIT))
  // The request channel stalls only behind a waiting result.
  `ASSERT_HOLDS(a_stall_cause, clk, rst, in_ready || (s1_valid && out_valid && !out_ready))
  // A fired check lands in the result register on the next edge.
  `ASSERT_NEXT(a_result_load, clk, rst, load_result, out_valid && new_status == $past(result.status))

endmodule
